@@ hw/rtl/sha256_message_padder_macros.svh @@
// Assertion macros for the SHA-256 message padder.
`ifndef SHA256_MESSAGE_PADDER_MACROS_SVH
`define SHA256_MESSAGE_PADDER_MACROS_SVH

`ifndef SYNTHESIS
// lbl: prop must hold at every clock edge out of reset
`define SHA_PAD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// lbl: expr must never be true out of reset
`define SHA_PAD_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define SHA_PAD_ASSERT(lbl, clk, rstn, prop, msg)
`define SHA_PAD_NEVER(lbl, clk, rstn, expr, msg)
`endif

`endif

@@ hw/rtl/sha_pad_pkg.sv @@
package sha_pad_pkg;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_MARK,
        ST_FILL,
        ST_LEN_LO
    } state_t;

    typedef enum logic [2:0] {
        SRC_BYTE,
        SRC_MARK,
        SRC_ZERO,
        SRC_LEN_HI,
        SRC_LEN_LO
    } src_t;

    typedef struct packed {
        logic take_byte;
        logic load;
        src_t src;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic word_done;
        logic wpos_14;
        logic wpos_15;
    } status_t;

    localparam logic [7:0]  PAD_BYTE     = 8'h80;
    localparam logic [63:0] BITS_PER_BYTE = 64'd8;
    localparam logic [3:0]  LEN_HI_POS   = 4'd14;
    localparam logic [3:0]  LAST_POS     = 4'd15;

endpackage

@@ hw/rtl/sha256_message_padder.sv @@
// channel | direction | tdata                          | tuser      | tlast
// s_      | in        | [7:0] data_byte                | byte_valid | last_item
// m_      | out       | [31:0] out_word, [35:32]       | -          | message_end
//         |           | word_index, [36] block_end     |            |
//
// One byte transaction per cycle while the output register drains each cycle.
// A last transaction adds the marker, fill and two length words: 3 to 18
// words more, one word per cycle while the output is not stalled, with s_tready low meanwhile.
// Reset (aresetn low, synchronous) clears the counters and the output valid flag, not the output data.
// Output stalls hold the single output register and back-pressure s_tready.
`include "sha256_message_padder_macros.svh"

module sha256_message_padder
    import sha_pad_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,  // [7:0] data_byte
    input  logic        s_tuser,  // [0] byte_valid
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,  // [31:0] out_word, [35:32] word_index, [36] block_end
    output logic        m_tlast
);

    cmd_t    cmd;
    status_t status;

    sha_pad_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .status   (status),
        .cmd      (cmd)
    );

    sha_pad_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .status   (status),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    `SHA_PAD_NEVER(a_no_overwrite, aclk, aresetn, cmd.load && !status.out_free, "result overwritten")
    `SHA_PAD_ASSERT(a_end_at_15, aclk, aresetn, m_tvalid && m_tlast |-> m_tdata[35:32] == LAST_POS && m_tdata[36], "message end off block end")
    `SHA_PAD_ASSERT(a_pad_blocks_in, aclk, aresetn, s_tvalid && s_tready && s_tlast |=> !s_tready, "input taken during padding")

endmodule

@@ hw/rtl/sha_pad_ctrl.sv @@
module sha_pad_ctrl
    import sha_pad_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  logic    s_tuser,
    input  logic    s_tlast,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg, state_next;
    logic   extra_reg, extra_next;
    logic   accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_RUN;
            extra_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            extra_reg <= extra_next;
        end
    end

    assign s_tready = (state_reg == ST_RUN) && status.out_free;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next    = state_reg;
        extra_next    = extra_reg;
        cmd.take_byte = 1'b0;
        cmd.load      = 1'b0;
        cmd.src       = SRC_ZERO;
        cmd.clear     = 1'b0;
        case (state_reg)
            ST_RUN: begin
                if (accept) begin
                    cmd.take_byte = s_tuser;
                    if (s_tuser && status.word_done) begin
                        cmd.load = 1'b1;
                        cmd.src  = SRC_BYTE;
                    end
                    if (s_tlast) begin
                        state_next = ST_MARK;
                    end
                end
            end
            ST_MARK: begin
                if (status.out_free) begin
                    cmd.load   = 1'b1;
                    cmd.src    = SRC_MARK;
                    // marker in word 14 leaves no room for the length: one extra block
                    extra_next = status.wpos_14;
                    state_next = ST_FILL;
                end
            end
            ST_FILL: begin
                if (status.out_free) begin
                    cmd.load = 1'b1;
                    if (status.wpos_14 && !extra_reg) begin
                        cmd.src    = SRC_LEN_HI;
                        state_next = ST_LEN_LO;
                    end else begin
                        cmd.src = SRC_ZERO;
                        if (status.wpos_15) begin
                            extra_next = 1'b0;
                        end
                    end
                end
            end
            ST_LEN_LO: begin
                if (status.out_free) begin
                    cmd.load   = 1'b1;
                    cmd.src    = SRC_LEN_LO;
                    cmd.clear  = 1'b1;
                    state_next = ST_RUN;
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase
    end

endmodule

@@ hw/rtl/sha_pad_dp.sv @@
module sha_pad_dp
    import sha_pad_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [7:0]  s_tdata,
    input  cmd_t        cmd,
    output status_t     status,
    input  logic        m_tready,
    output logic        m_tvalid,
    output logic [39:0] m_tdata,
    output logic        m_tlast
);

    logic [63:0] bit_count_reg, bit_count_next;
    logic [31:0] acc_reg, acc_next;
    logic [3:0]  wpos_reg, wpos_next;
    logic [1:0]  bpos_reg, bpos_next;

    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_word_reg;
    logic [3:0]  out_idx_reg;
    logic        out_bend_reg;
    logic        out_mend_reg;

    logic [31:0] shifted;
    logic [31:0] mark_word;
    logic [31:0] sel_word;

    assign shifted = {acc_reg[23:0], s_tdata};

    always_comb begin
        case (bpos_reg)
            2'd0:    mark_word = {PAD_BYTE, 24'h0};
            2'd1:    mark_word = {acc_reg[7:0], PAD_BYTE, 16'h0};
            2'd2:    mark_word = {acc_reg[15:0], PAD_BYTE, 8'h0};
            default: mark_word = {acc_reg[23:0], PAD_BYTE};
        endcase
    end

    always_comb begin
        case (cmd.src)
            SRC_BYTE:   sel_word = shifted;
            SRC_MARK:   sel_word = mark_word;
            SRC_LEN_HI: sel_word = bit_count_reg[63:32];
            SRC_LEN_LO: sel_word = bit_count_reg[31:0];
            default:    sel_word = 32'h0;
        endcase
    end

    always_comb begin
        bit_count_next = bit_count_reg;
        acc_next       = acc_reg;
        wpos_next      = wpos_reg;
        bpos_next      = bpos_reg;
        if (cmd.take_byte) begin
            bit_count_next = bit_count_reg + BITS_PER_BYTE;
            bpos_next      = bpos_reg + 2'd1;
            acc_next       = (bpos_reg == 2'd3) ? 32'h0 : shifted;
        end
        if (cmd.load) begin
            wpos_next = wpos_reg + 4'd1;
        end
        if (cmd.clear) begin
            bit_count_next = 64'h0;
            acc_next       = 32'h0;
            bpos_next      = 2'd0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg && !m_tready;
        if (cmd.load) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_count_reg <= 64'h0;
            acc_reg       <= 32'h0;
            wpos_reg      <= 4'd0;
            bpos_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end else begin
            bit_count_reg <= bit_count_next;
            acc_reg       <= acc_next;
            wpos_reg      <= wpos_next;
            bpos_reg      <= bpos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            out_word_reg <= sel_word;
            out_idx_reg  <= wpos_reg;
            out_bend_reg <= (wpos_reg == LAST_POS);
            out_mend_reg <= (cmd.src == SRC_LEN_LO);
        end
    end

    assign status.out_free  = !out_valid_reg || m_tready;
    assign status.word_done = (bpos_reg == 2'd3);
    assign status.wpos_14   = (wpos_reg == LEN_HI_POS);
    assign status.wpos_15   = (wpos_reg == LAST_POS);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_bend_reg, out_idx_reg, out_word_reg};
    assign m_tlast  = out_mend_reg;

endmodule

@@ dv/sha256_message_padder_tb.sv @@
module sha256_message_padder_tb;
    import sha_pad_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS  = 20;

    typedef struct packed {
        logic [31:0] word;
        logic [3:0]  idx;
        logic        blk_end;
        logic        msg_end;
    } pad_word_t;

    class pad_word_tracker;
        logic [63:0] bits;
        logic [31:0] acc;
        logic [3:0]  wpos;
        logic [1:0]  bpos;
        pad_word_t   pending_words[$];
        int          errors;

        function new();
            clear_message();
            errors = 0;
        endfunction

        function void clear_message();
            bits = '0;
            acc  = '0;
            wpos = '0;
            bpos = '0;
        endfunction

        function void push_word(logic [31:0] w, logic m);
            pad_word_t e;
            e.word    = w;
            e.idx     = wpos;
            e.blk_end = (wpos == LAST_POS);
            e.msg_end = m;
            pending_words.push_back(e);
            wpos = wpos + 4'd1;
        endfunction

        // accepted input transaction
        function void take_item(logic [7:0] b, logic v, logic l);
            logic [3:0]  first_pos;
            logic [31:0] mark;
            if (v) begin
                acc  = {acc[23:0], b};
                bits = bits + BITS_PER_BYTE;
                bpos = bpos + 2'd1;
                if (bpos == 2'd0) begin
                    push_word(acc, 1'b0);
                    acc = '0;
                end
            end
            if (l) begin
                first_pos = wpos;
                case (bpos)
                    2'd0: mark = {PAD_BYTE, 24'h0};
                    2'd1: mark = {acc[7:0], PAD_BYTE, 16'h0};
                    2'd2: mark = {acc[15:0], PAD_BYTE, 8'h0};
                    default: mark = {acc[23:0], PAD_BYTE};
                endcase
                push_word(mark, 1'b0);
                // marker in the length words: spill into an extra block
                if (first_pos >= LEN_HI_POS) begin
                    while (wpos != 4'd0) push_word(32'h0, 1'b0);
                end
                while (wpos != LEN_HI_POS) push_word(32'h0, 1'b0);
                push_word(bits[63:32], 1'b0);
                push_word(bits[31:0], 1'b1);
                clear_message();
            end
        endfunction

        // accepted output transaction
        function void check_word(logic [31:0] w, logic [3:0] idx, logic be, logic me);
            pad_word_t e;
            if (pending_words.size() == 0) begin
                $error("unexpected output transaction: out_word=%h word_index=%0d", w, idx);
                errors++;
                return;
            end
            e = pending_words.pop_front();
            if (w !== e.word) begin
                $error("out_word: expected %h, got %h", e.word, w);
                errors++;
            end
            if (idx !== e.idx) begin
                $error("word_index: expected %0d, got %0d", e.idx, idx);
                errors++;
            end
            if (be !== e.blk_end) begin
                $error("block_end: expected %0b, got %0b", e.blk_end, be);
                errors++;
            end
            if (me !== e.msg_end) begin
                $error("message_end: expected %0b, got %0b", e.msg_end, me);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tuser  = 1'b0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;

    pad_word_tracker tracker = new();
    int idle_pct   = 0;
    int stall_pct  = 0;
    int byte_items = 0;
    int cycle_count = 0;

    sha256_message_padder DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                tracker.take_item(s_tdata, s_tuser, s_tlast);
            if (m_tvalid && m_tready)
                tracker.check_word(m_tdata[31:0], m_tdata[35:32], m_tdata[36], m_tlast);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_item(input logic [7:0] b, input logic v, input logic l);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= v;
        s_tlast  <= l;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (v || l)
            byte_items++;
    endtask

    // nbytes message bytes; the final byte carries last when last_on_byte is set
    task automatic send_message(input int nbytes, input bit last_on_byte);
        for (int i = 0; i < nbytes; i++) begin
            if ($urandom_range(9) == 0)
                send_item(8'($urandom), 1'b0, 1'b0);
            send_item(8'($urandom), 1'b1, last_on_byte && (i == nbytes - 1));
        end
        if (!last_on_byte || nbytes == 0)
            send_item(8'($urandom), 1'b0, 1'b1);
    endtask

    initial begin
        int n;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'hA5, 1'b0, 1'b1);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'h7F, 1'b1, 1'b1);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'h01, 1'b1, 1'b0);
        send_item(8'hFF, 1'b0, 1'b1);
        send_item(8'h5A, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'hC3, 1'b1, 1'b1);
        send_item(8'h11, 1'b1, 1'b0);
        send_item(8'h22, 1'b1, 1'b0);
        send_item(8'h33, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);

        // random: no idling, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = (ph == 1) ? 79 : (ph == 3) ? 17 : 0;
            stall_pct = (ph == 2) ? 79 : (ph == 3) ? 17 : 0;
            byte_items = 0;
            // marker lands in word 14 or 15
            if (ph == 0)
                send_message(56 + $urandom_range(7), 1'($urandom_range(1)));
            while (byte_items < PHASE_ITEMS) begin
                n = ($urandom_range(9) == 0) ? $urandom_range(66, 48) : $urandom_range(12);
                send_message(n, (n > 0) && ($urandom_range(1) == 1));
            end
        end
        s_tvalid <= 1'b0;

        while (tracker.pending_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (tracker.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
